// File: src/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg: shared types and constants for the table interpolator
// Item layouts, status and opcode codes, and the sequencer state encodings.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int FIELD_W     = 32;   // width of x, y and result fields
    localparam int INDEX_W     = 4;    // point_index field width
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 5;    // points_in_use register width

    localparam int DEF_MAX_POINTS  = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [CFG_W-1:0] POINTS_RESET = 5'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSIDE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WRITE   = 2'd2;

    typedef struct packed {
        logic                      opcode;
        logic [INDEX_W-1:0]        point_index;
        logic signed [FIELD_W-1:0] x_value;
        logic signed [FIELD_W-1:0] y_value;
    } in_item_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] y_result;
        logic [STATUS_W-1:0]       status;
    } out_item_t;

    // top level sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_SETUP,
        ST_START,
        ST_WAIT,
        ST_DONE
    } seq_state_t;

    // shared multiply / divide unit
    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CAP,
        MD_DIV
    } md_state_t;

endpackage

// File: src/plti_table_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_table_mem: breakpoint table storage
// One write port, one read port with registered read data. No reset.
// ----------------------------------------------------------------------------
module plti_table_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/plti_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_muldiv: iterative (a*b)/d on unsigned magnitudes
// One shared adder does shift-add multiply, an overflow check, then
// restoring division. Quotients of 2^MW or more are reported as 2^MW.
// ----------------------------------------------------------------------------
module plti_muldiv
    import plti_pkg::*;
#(
    parameter int MW = 33
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] mcand,     // |dy|
    input  logic [MW-1:0] mplier,    // |x - xlo|
    input  logic [MW-1:0] divisor,   // |dx|, nonzero
    output logic          done,
    output logic [MW:0]   quotient
);

    localparam int CNTW = $clog2(MW);

    md_state_t       state_reg, state_next;
    logic [MW-1:0]   mcand_reg, mcand_next;
    logic [MW-1:0]   dvsr_reg, dvsr_next;
    logic [MW-1:0]   hi_reg, hi_next;
    logic [MW-1:0]   lo_reg, lo_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            cap_reg, cap_next;
    logic            done_reg, done_next;

    // shared adder
    logic [MW:0]     add_a, add_b;
    logic            add_cin;
    logic [MW+1:0]   add_sum;
    logic [MW:0]     div_t;

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (MW+2)'(add_cin);
    assign div_t   = {hi_reg, lo_reg[MW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        dvsr_reg  <= dvsr_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        cnt_reg   <= cnt_next;
        cap_reg   <= cap_next;
    end

    always_comb begin
        state_next = state_reg;
        mcand_next = mcand_reg;
        dvsr_next  = dvsr_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        done_next  = 1'b0;
        add_a      = {1'b0, hi_reg};
        add_b      = '0;
        add_cin    = 1'b0;

        unique case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    mcand_next = mcand;
                    dvsr_next  = divisor;
                    hi_next    = '0;
                    lo_next    = mplier;
                    cnt_next   = CNTW'(MW - 1);
                    cap_next   = 1'b0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL: begin
                add_b   = lo_reg[0] ? {1'b0, mcand_reg} : '0;
                hi_next = add_sum[MW:1];
                lo_next = {add_sum[0], lo_reg[MW-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = MD_CAP;
                end
            end
            MD_CAP: begin
                // upper product half >= divisor means quotient >= 2^MW
                add_b   = ~{1'b0, dvsr_reg};
                add_cin = 1'b1;
                cnt_next = CNTW'(MW - 1);
                if (add_sum[MW+1]) begin
                    cap_next   = 1'b1;
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end else begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV: begin
                add_a   = div_t;
                add_b   = ~{1'b0, dvsr_reg};
                add_cin = 1'b1;
                hi_next = add_sum[MW+1] ? add_sum[MW-1:0] : div_t[MW-1:0];
                lo_next = {lo_reg[MW-2:0], add_sum[MW+1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = cap_reg ? {1'b1, {MW{1'b0}}} : {1'b0, lo_reg};

    // partial remainder always stays below the divisor
    a_rem_below_dvsr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MD_DIV) |-> (hi_reg < dvsr_reg))
        else $error("partial remainder not below divisor");

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == MD_IDLE))
        else $error("muldiv started while busy");

endmodule

// File: src/piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator: breakpoint table with linear interp
// Stores up to MAX_POINTS (x, y) breakpoints and evaluates
// ylo + (yhi - ylo) * (x - xlo) / (xhi - xlo) on request.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item in. opcode OP_WRITE stores
//   (x_value, y_value) at point_index (an index >= MAX_POINTS is dropped)
//   and answers STATUS_WRITE with a zero result. OP_EVAL interpolates at
//   x_value over the first points_in_use breakpoints (x rising).
//   x outside the table returns the end y with STATUS_CLAMPED.
//   m_valid/m_ready/m_data carry one result item out per input item.
//   cfg_wr_en/cfg_wr_data set points_in_use (clamped to 2..MAX_POINTS);
//   write it only while the block is idle.
// Flow (MW = VALUE_WIDTH + 1, VALUE_WIDTH capped at 32): a write item goes
//   straight to ST_DONE. An eval below the table ends in ST_FIRST, one
//   above it in ST_LAST. An interior eval scans for the upper breakpoint,
//   then multiplies, checks for overflow and divides (an overflowing
//   quotient skips the divide, a zero-width segment the whole muldiv). The
//   shift-add multiply and restoring divide (MW steps each, one shared adder)
//   dominate; s_ready stays low while an item is at work, back with m_valid.
// Reset: control clears, points_in_use returns to 2; table contents are
//   undefined until written.
// Stall: a finished result sits in the output register; the next item may
//   be accepted meanwhile, but its result waits until the register frees.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator
    import plti_pkg::*;
#(
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input items
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    // result items
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    // configuration
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    // effective value width: never wider than the 32-bit fields
    localparam int VW = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int MW = VW + 1;              // differences and magnitudes
    localparam int SW = MW + 2;              // final sum before saturation
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NB = $clog2(MAX_POINTS + 1);
    localparam int NW = (NB > CFG_W) ? NB : CFG_W;
    localparam int DW = 2 * VW;

    localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (VW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-(64'sd1 <<< (VW - 1)));

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    seq_state_t              state_reg, state_next;
    logic [CFG_W-1:0]        piu_reg;
    logic signed [VW-1:0]    x_reg, x_next;
    logic signed [VW-1:0]    lo_x_reg, lo_x_next;
    logic signed [VW-1:0]    lo_y_reg, lo_y_next;
    logic signed [VW-1:0]    hi_x_reg, hi_x_next;
    logic signed [VW-1:0]    hi_y_reg, hi_y_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic signed [MW-1:0]    dx_reg, dx_next;
    logic signed [MW-1:0]    dy_reg, dy_next;
    logic signed [MW-1:0]    off_reg, off_next;
    logic                    neg_reg, neg_next;
    logic signed [VW-1:0]    res_reg, res_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    // ------------------------------------------------------------------
    // table and shared arithmetic unit
    // ------------------------------------------------------------------
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [AW-1:0]           rd_addr;
    logic [DW-1:0]           rd_data;
    logic signed [VW-1:0]    rd_x, rd_y;
    logic                    write_ok;

    logic                    md_start;
    logic                    md_done;
    logic [MW:0]             md_q;
    logic [MW-1:0]           mag_dx, mag_dy, mag_off;

    logic [NW-1:0]           piu_ext, n_eff;
    logic [AW-1:0]           last_idx;
    logic signed [SW-1:0]    ylo_ext, q_ext, sum;

    assign mem_waddr = AW'(s_data.point_index);
    assign write_ok  = (32'(s_data.point_index) < 32'(MAX_POINTS));
    assign rd_x      = rd_data[DW-1:VW];
    assign rd_y      = rd_data[VW-1:0];

    plti_table_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data ({s_data.x_value[VW-1:0], s_data.y_value[VW-1:0]}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // magnitudes; -2^VW maps to 2^VW, which still fits MW unsigned bits
    assign mag_dx  = dx_reg[MW-1]  ? MW'(-dx_reg)  : MW'(dx_reg);
    assign mag_dy  = dy_reg[MW-1]  ? MW'(-dy_reg)  : MW'(dy_reg);
    assign mag_off = off_reg[MW-1] ? MW'(-off_reg) : MW'(off_reg);

    plti_muldiv #(
        .MW (MW)
    ) u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (md_start),
        .mcand    (mag_dy),
        .mplier   (mag_off),
        .divisor  (mag_dx),
        .done     (md_done),
        .quotient (md_q)
    );

    // point count clamped to 2..MAX_POINTS
    assign piu_ext = NW'(piu_reg);
    always_comb begin
        priority if (piu_ext < NW'(2)) begin
            n_eff = NW'(2);
        end else if (piu_ext > NW'(MAX_POINTS)) begin
            n_eff = NW'(MAX_POINTS);
        end else begin
            n_eff = piu_ext;
        end
    end
    assign last_idx = AW'(n_eff - NW'(1));

    // final sum; a capped quotient already lies outside the value range
    assign ylo_ext = SW'(lo_y_reg);
    assign q_ext   = $signed({1'b0, md_q});
    assign sum     = neg_reg ? (ylo_ext - q_ext) : (ylo_ext + q_ext);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            piu_reg     <= POINTS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                piu_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        lo_x_reg   <= lo_x_next;
        lo_y_reg   <= lo_y_next;
        hi_x_reg   <= hi_x_next;
        hi_y_reg   <= hi_y_next;
        idx_reg    <= idx_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        off_reg    <= off_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------
    // sequencer: clamp checks, linear segment scan, then muldiv
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        x_next       = x_reg;
        lo_x_next    = lo_x_reg;
        lo_y_next    = lo_y_reg;
        hi_x_next    = hi_x_reg;
        hi_y_next    = hi_y_reg;
        idx_next     = idx_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        off_next     = off_reg;
        neg_next     = neg_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        rd_addr      = '0;
        md_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.opcode == OP_WRITE) begin
                        mem_we      = write_ok;
                        res_next    = '0;
                        status_next = STATUS_WRITE;
                        state_next  = ST_DONE;
                    end else begin
                        x_next     = s_data.x_value[VW-1:0];
                        state_next = ST_FIRST;   // entry 0 read this cycle
                    end
                end
            end
            ST_FIRST: begin
                lo_x_next = rd_x;
                lo_y_next = rd_y;
                if (x_reg < rd_x) begin
                    res_next    = rd_y;
                    status_next = STATUS_CLAMPED;
                    state_next  = ST_DONE;
                end else begin
                    rd_addr    = last_idx;
                    state_next = ST_LAST;
                end
            end
            ST_LAST: begin
                if (x_reg > rd_x) begin
                    res_next    = rd_y;
                    status_next = STATUS_CLAMPED;
                    state_next  = ST_DONE;
                end else begin
                    rd_addr    = AW'(1);
                    idx_next   = AW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // first x above the argument, or the last segment
                if ((rd_x > x_reg) || (idx_reg == last_idx)) begin
                    hi_x_next  = rd_x;
                    hi_y_next  = rd_y;
                    state_next = ST_SETUP;
                end else begin
                    lo_x_next = rd_x;
                    lo_y_next = rd_y;
                    idx_next  = idx_reg + 1'b1;
                    rd_addr   = idx_reg + 1'b1;
                end
            end
            ST_SETUP: begin
                dx_next    = MW'(hi_x_reg) - MW'(lo_x_reg);
                dy_next    = MW'(hi_y_reg) - MW'(lo_y_reg);
                off_next   = MW'(x_reg) - MW'(lo_x_reg);
                state_next = ST_START;
            end
            ST_START: begin
                status_next = STATUS_INSIDE;
                if (dx_reg == '0) begin
                    // zero-width segment gives ylo
                    res_next   = lo_y_reg;
                    state_next = ST_DONE;
                end else begin
                    neg_next   = dy_reg[MW-1] ^ off_reg[MW-1] ^ dx_reg[MW-1];
                    md_start   = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (md_done) begin
                    priority if (sum > SAT_MAX) begin
                        res_next = VW'(SAT_MAX);
                    end else if (sum < SAT_MIN) begin
                        res_next = VW'(SAT_MIN);
                    end else begin
                        res_next = VW'(sum);
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.y_result = FIELD_W'(res_reg);
                    m_data_next.status   = status_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready still high after an item was taken");

    a_write_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STATUS_WRITE)) |-> (m_data.y_result == '0))
        else $error("write item returned a nonzero result");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (idx_reg <= last_idx))
        else $error("segment scan ran past the last breakpoint");

endmodule

// File: tb/tb_piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interpolator: self-checking bench for the table
// interpolator
// Loads breakpoint tables, evaluates at and around breakpoints, at the table
// ends and at extreme arguments, under many point-count settings, with random
// idle cycles on the input side and random back-pressure on the result side.
// Each result item is checked against an in-bench prediction of the block.
// ----------------------------------------------------------------------------

// Shadow of the breakpoint table and point count, plus the queue of results
// still owed by the block.
class interp_scoreboard;
    logic signed [31:0]                 bp_x [plti_pkg::DEF_MAX_POINTS];
    logic signed [31:0]                 bp_y [plti_pkg::DEF_MAX_POINTS];
    logic [plti_pkg::CFG_W-1:0]         points_reg;
    plti_pkg::out_item_t                pending [$];
    int unsigned                        mismatches;
    int unsigned                        writes_seen;
    int unsigned                        inside_seen;
    int unsigned                        clamped_seen;

    function new();
        foreach (bp_x[k]) begin
            bp_x[k] = '0;
            bp_y[k] = '0;
        end
        points_reg   = plti_pkg::POINTS_RESET;
        mismatches   = 0;
        writes_seen  = 0;
        inside_seen  = 0;
        clamped_seen = 0;
    endfunction

    // register value is clamped to 2..MAX_POINTS at use
    function int effective_points();
        if (points_reg < 2)
            return 2;
        if (points_reg > plti_pkg::DEF_MAX_POINTS)
            return plti_pkg::DEF_MAX_POINTS;
        return int'(points_reg);
    endfunction

    function plti_pkg::out_item_t interpolate(logic signed [31:0] x);
        plti_pkg::out_item_t r;
        int                  n;
        int                  i;
        logic signed [33:0]  dx;
        logic signed [33:0]  dy;
        logic signed [33:0]  off;
        logic [33:0]         mdx;
        logic [33:0]         mdy;
        logic [33:0]         moff;
        logic [66:0]         quo;
        longint              q;
        longint              total;
        bit                  neg;
        n = effective_points();
        r.y_result = '0;
        r.status   = plti_pkg::STATUS_INSIDE;
        if (x < bp_x[0]) begin
            r.y_result = bp_y[0];
            r.status   = plti_pkg::STATUS_CLAMPED;
        end else if (x > bp_x[n-1]) begin
            r.y_result = bp_y[n-1];
            r.status   = plti_pkg::STATUS_CLAMPED;
        end else begin
            // first upper breakpoint above x, else the last segment
            i = 1;
            while (i < n - 1 && bp_x[i] <= x)
                i++;
            dx  = bp_x[i] - bp_x[i-1];
            dy  = bp_y[i] - bp_y[i-1];
            off = x - bp_x[i-1];
            if (dx == 0) begin
                r.y_result = bp_y[i-1];
            end else begin
                mdx  = (dx < 0) ? -dx : dx;
                mdy  = (dy < 0) ? -dy : dy;
                moff = (off < 0) ? -off : off;
                quo  = (mdy * moff) / mdx;
                if (quo >= (67'd1 << 62))
                    q = longint'(64'h4000_0000_0000_0000);
                else
                    q = longint'({1'b0, quo[62:0]});
                neg   = ((dy < 0) != (off < 0)) != (dx < 0);
                total = neg ? longint'(bp_y[i-1]) - q : longint'(bp_y[i-1]) + q;
                if (total > 64'sd2147483647)
                    r.y_result = 32'sh7fffffff;
                else if (total < -64'sd2147483648)
                    r.y_result = 32'sh80000000;
                else
                    r.y_result = total[31:0];
            end
        end
        return r;
    endfunction

    function void note_accepted(plti_pkg::in_item_t item);
        plti_pkg::out_item_t e;
        if (item.opcode == plti_pkg::OP_WRITE) begin
            if (int'(item.point_index) < plti_pkg::DEF_MAX_POINTS) begin
                bp_x[item.point_index] = item.x_value;
                bp_y[item.point_index] = item.y_value;
            end
            e.y_result = '0;
            e.status   = plti_pkg::STATUS_WRITE;
        end else begin
            e = interpolate(item.x_value);
        end
        pending.push_back(e);
    endfunction

    function void check_result(plti_pkg::out_item_t got);
        plti_pkg::out_item_t e;
        if (pending.size() == 0) begin
            $error("result item with nothing outstanding: y_result %0d, status %0d",
                   got.y_result, got.status);
            mismatches++;
        end else begin
            e = pending.pop_front();
            if (got.y_result !== e.y_result) begin
                $error("y_result mismatch: expected %0d, actual %0d",
                       e.y_result, got.y_result);
                mismatches++;
            end
            if (got.status !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
                mismatches++;
            end
            case (e.status)
                plti_pkg::STATUS_WRITE:   writes_seen++;
                plti_pkg::STATUS_CLAMPED: clamped_seen++;
                default:                  inside_seen++;
            endcase
        end
    endfunction
endclass

module tb_piecewise_linear_table_interpolator;
    import plti_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    // Bound for the watchdog: ~2000 items, each with its time in the block and
    // idle stretches on both sides, stay far below this.
    localparam int CYCLE_LIMIT  = 2_000_000;
    // settle time after the last result, with margin over an interior evaluation
    localparam int SETTLE_CYCLES = 150;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_item_t         s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_item_t        m_data;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    interp_scoreboard sb;
    int               cycle_count     = 0;
    int               items_sent      = 0;
    int               settings_used   = 0;
    int               stall_left      = 0;
    bit               sender_idles    = 1'b0;
    bit               receiver_stalls = 1'b0;

    piecewise_linear_table_interpolator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a lost or stuck item ends the run here.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $error("timed out with %0d result items outstanding", sb.pending.size());
        $display("FAIL");
        $finish;
    end

    // Mostly short idle stretches, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: check every accepted item, then pick next cycle's m_ready.
    // Values read here are the ones present at the edge (NBA updates come later).
    always @(posedge aclk) begin : result_side
        logic next_ready;
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
        next_ready = 1'b1;
        if (receiver_stalls) begin
            if (stall_left > 0) begin
                stall_left--;
                next_ready = 1'b0;
            end else if ($urandom_range(0, 99) < 30) begin
                stall_left = pick_gap() - 1;
                next_ready = 1'b0;
            end
        end
        m_ready <= next_ready;
    end

    function automatic in_item_t make_write(input logic [INDEX_W-1:0] idx,
                                            input logic signed [31:0] x,
                                            input logic signed [31:0] y);
        in_item_t item;
        item.opcode      = OP_WRITE;
        item.point_index = idx;
        item.x_value     = x;
        item.y_value     = y;
        return item;
    endfunction

    // index and y are don't-care on evaluate; keep them random
    function automatic in_item_t make_eval(input logic signed [31:0] x);
        in_item_t item;
        item.opcode      = OP_EVAL;
        item.point_index = INDEX_W'($urandom);
        item.x_value     = x;
        item.y_value     = $urandom;
        return item;
    endfunction

    // Present one item and hold it until accepted. On a zero gap valid stays
    // high, so the next call just swaps the payload in the same step.
    task automatic send_item(input in_item_t item);
        int gap;
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_accepted(item);
        items_sent++;
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) < 35)
            gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Sender holds off until every outstanding result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
    endtask

    // points_in_use may only change with the block idle
    task automatic write_points(input logic [CFG_W-1:0] value);
        wait_for_results();
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.points_reg = value;
        settings_used++;
    endtask

    // Reload all slots in shuffled order.
    //   0: rising, random stride    1: full 32-bit span, extreme y
    //   2: rising with repeated x   3: no order at all
    task automatic load_table(input int kind);
        logic signed [31:0] xs [DEF_MAX_POINTS];
        logic signed [31:0] ys [DEF_MAX_POINTS];
        int                 order [DEF_MAX_POINTS];
        longint             cur;
        longint             stride_max;
        int                 j;
        int                 t;
        stride_max = longint'(1) << $urandom_range(0, 28);
        cur = -stride_max * 8 + longint'($urandom_range(0, 1000)) - 500;
        for (int k = 0; k < DEF_MAX_POINTS; k++) begin
            if (k > 0) begin
                if (kind == 2 && $urandom_range(0, 2) == 0)
                    cur = cur;
                else
                    cur = cur + longint'($urandom_range(1, 32'(stride_max)));
            end
            if (cur > 64'sd2147483647)
                cur = 64'sd2147483647;
            if (cur < -64'sd2147483648)
                cur = -64'sd2147483648;
            ys[k] = $urandom;
            case (kind)
                1: begin
                    xs[k] = 32'(-64'sd2147483648 + longint'(k) * 64'sd286331153);
                    if ($urandom_range(0, 3) != 0)
                        ys[k] = (k % 2 == 1) ? 32'sh7fffffff : 32'sh80000000;
                end
                3:       xs[k] = $urandom;
                default: xs[k] = cur[31:0];
            endcase
            order[k] = k;
        end
        for (int k = DEF_MAX_POINTS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        for (int k = 0; k < DEF_MAX_POINTS; k++)
            send_item(make_write(INDEX_W'(order[k]), xs[order[k]], ys[order[k]]));
    endtask

    // Arguments that hit breakpoints, their neighbors, the interior of the
    // active range, anything at all, and the field extremes.
    function automatic logic signed [31:0] pick_eval_x();
        int                 n;
        int                 k;
        longint             lo;
        longint             hi;
        longint             span;
        logic signed [31:0] x;
        n = sb.effective_points();
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1, 2: x = sb.bp_x[k];
            3, 4:    x = sb.bp_x[k] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
            5, 6, 7: begin
                lo   = sb.bp_x[0];
                hi   = sb.bp_x[n-1];
                span = hi - lo;
                if (span <= 0)
                    x = sb.bp_x[0];
                else
                    x = 32'(lo + longint'({$urandom, $urandom} % 64'(span + 1)));
            end
            8:       x = $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0:       x = 32'sh80000000;
                    1:       x = 32'sh7fffffff;
                    2:       x = 32'sd0;
                    default: x = -32'sd1;
                endcase
            end
        endcase
        return x;
    endfunction

    initial begin
        int                 phase;
        int                 random_start;
        int                 phase_items;
        int                 r;
        int                 k;
        logic [CFG_W-1:0]   pv;
        logic [INDEX_W-1:0] slot;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // ---------------- directed part ----------------
        // Fill every slot first so no evaluation ever touches an unwritten
        // entry. y0/y1 at the field extremes make the first segment's dy
        // span the full 32-bit range.
        for (k = 0; k < DEF_MAX_POINTS; k++)
            send_item(make_write(INDEX_W'(k),
                                 32'(-1073741824 + k * 134217728),
                                 (k == 0) ? 32'sh80000000 :
                                 (k == 1) ? 32'sh7fffffff :
                                            32'(k * 7654321 - 50000000)));
        // point count is still at its reset value of 2
        send_item(make_eval(32'sh80000000));            // below the table
        send_item(make_eval(32'sh7fffffff));            // above the table
        send_item(make_eval(sb.bp_x[1]));               // equal to last x
        send_item(make_eval(sb.bp_x[0]));               // equal to first x
        send_item(make_eval(sb.bp_x[0] + 32'sd12345));  // inside, huge slope
        // collapse the segment to zero width, evaluate on it, then restore
        send_item(make_write(4'd1, sb.bp_x[0], 32'sd777));
        send_item(make_eval(sb.bp_x[0]));
        send_item(make_write(4'd1, 32'(-1073741824 + 134217728), 32'sh7fffffff));
        send_item(make_eval(-32'sd1000000000));

        // ---------------- random part ----------------
        // Each phase: drain, new point count, maybe a fresh table, then a
        // burst of evaluations with some single-slot rewrites.
        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            // walk the clamp corners first, then mostly legal counts
            case (phase)
                0:       pv = 5'd16;
                1:       pv = 5'd0;
                2:       pv = 5'd31;
                3:       pv = 5'd1;
                4:       pv = 5'd17;
                default: begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        pv = CFG_W'($urandom);
                    else if (r == 1)
                        pv = ($urandom_range(0, 1) != 0) ? 5'd2 : 5'd16;
                    else
                        pv = CFG_W'($urandom_range(2, 16));
                end
            endcase
            write_points(pv);
            // some phases run flat out on both sides
            sender_idles    = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 99) < 40) begin
                r = $urandom_range(0, 99);
                load_table((r < 50) ? 0 : (r < 65) ? 1 : (r < 80) ? 2 : 3);
            end
            phase_items = $urandom_range(20, 120);
            repeat (phase_items) begin
                if ($urandom_range(0, 99) < 15) begin
                    slot = INDEX_W'($urandom);
                    // half keep the x in place so sorted tables stay sorted
                    if ($urandom_range(0, 1) != 0)
                        send_item(make_write(slot, sb.bp_x[slot], $urandom));
                    else
                        send_item(make_write(slot, $urandom, $urandom));
                end else begin
                    send_item(make_eval(pick_eval_x()));
                end
            end
            phase++;
        end

        // ---------------- wind down ----------------
        // After the last result, watch a while longer for stray items.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Checked %0d breakpoint writes, %0d interior and %0d clamped evaluations,",
                 sb.writes_seen, sb.inside_seen, sb.clamped_seen);
        $display("over %0d point-count settings with random idling on both sides.",
                 settings_used);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
